FILE: rtl/piecewise_linear_vector_interp_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise linear vector interpolation unit
// Clocked implication macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_VECTOR_INTERP_UNIT_ASSERT_SVH
`define PIECEWISE_LINEAR_VECTOR_INTERP_UNIT_ASSERT_SVH

// Same-cycle implication, masked during reset
`define PWL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset
`define PWL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pwl_pkg.sv
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared widths, codes and status types of the interpolation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pwl_pkg;

    localparam int FUNC_W   = 1;
    localparam int SLOT_W   = 4;
    localparam int HEIGHT_W = 24;
    localparam int DISP_W   = 16;
    localparam int TAG_W    = 20;
    localparam int COUNT_W  = 5;
    localparam int KIND_W   = 2;
    localparam int ENTRY_W  = HEIGHT_W + 3 * DISP_W;

    // Item function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

    // Segment kind codes
    localparam logic [KIND_W-1:0] SEG_BELOW  = 2'd0;
    localparam logic [KIND_W-1:0] SEG_INTERP = 2'd1;
    localparam logic [KIND_W-1:0] SEG_BEYOND = 2'd2;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/pwl_item_if.sv
// ----------------------------------------------------------------------------
// pwl_item_if
// Input item channel: load or query, with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwl_item_if;
    logic                                 valid;
    logic                                 ready;
    logic [pwl_pkg::FUNC_W-1:0]           func;
    logic [pwl_pkg::SLOT_W-1:0]           slot;
    logic [pwl_pkg::HEIGHT_W-1:0]         height;
    logic signed [pwl_pkg::DISP_W-1:0]    load_dx;
    logic signed [pwl_pkg::DISP_W-1:0]    load_dy;
    logic signed [pwl_pkg::DISP_W-1:0]    load_dz;
    logic [pwl_pkg::TAG_W-1:0]            vertex_id;
    logic [pwl_pkg::HEIGHT_W-1:0]         distance;

    modport source (
        output valid, func, slot, height, load_dx, load_dy, load_dz, vertex_id, distance,
        input  ready
    );
    modport sink (
        input  valid, func, slot, height, load_dx, load_dy, load_dz, vertex_id, distance,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/pwl_result_if.sv
// ----------------------------------------------------------------------------
// pwl_result_if
// Result channel: interpolated displacement with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwl_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [pwl_pkg::TAG_W-1:0]            tag;
    logic signed [pwl_pkg::DISP_W-1:0]    out_dx;
    logic signed [pwl_pkg::DISP_W-1:0]    out_dy;
    logic signed [pwl_pkg::DISP_W-1:0]    out_dz;
    logic [pwl_pkg::KIND_W-1:0]           segment_kind;

    modport source (
        output valid, tag, out_dx, out_dy, out_dz, segment_kind,
        input  ready
    );
    modport sink (
        input  valid, tag, out_dx, out_dy, out_dz, segment_kind,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/pwl_cfg_if.sv
// ----------------------------------------------------------------------------
// pwl_cfg_if
// Configuration write channel for the breakpoint count register.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwl_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pwl_pkg::COUNT_W-1:0]   breakpoint_count;

    modport source (output valid, breakpoint_count, input ready);
    modport sink   (input valid, breakpoint_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/pwl_ram.sv
// ----------------------------------------------------------------------------
// pwl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/pwl_div.sv
// ----------------------------------------------------------------------------
// pwl_div
// Restoring divider: fraction = (num << FRACTION_BITS) / den, one bit a cycle.
// Requires 0 < num <= den, so the quotient fits FRACTION_BITS + 1 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pwl_div #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [pwl_pkg::HEIGHT_W-1:0]      num,
    input  logic [pwl_pkg::HEIGHT_W-1:0]      den,
    output logic [FRACTION_BITS:0]            quot,
    output pwl_pkg::div_stat_t                stat
);

    localparam int QW    = FRACTION_BITS + 1;
    localparam int CNT_W = $clog2(QW + 1);
    localparam int HW    = pwl_pkg::HEIGHT_W;

    logic [HW:0]      rem_reg, rem_next;
    logic [HW-1:0]    den_reg, den_next;
    logic [QW-1:0]    quot_reg, quot_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic             ge;
    logic [HW:0]      diff;

    // One compare-subtract step
    always_comb
    begin
        ge   = rem_reg >= {1'b0, den_reg};
        diff = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
    end

    // Advance the iteration
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {1'b0, num};
            den_next  = den;
            quot_next = '0;
            cnt_next  = CNT_W'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = {diff[HW-1:0], 1'b0};
            quot_next = {quot_reg[QW-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

FILE: rtl/piecewise_linear_vector_interp_unit.sv
// Load: no result; the next item may be taken at the following edge.
// Query, interpolated: serial scan, one table read a cycle, one quotient bit a cycle, then
// one shared multiplier over three components; the next item is taken once the result
// is registered. At or below the first breakpoint the first entry is returned; beyond
// the n entries in use, or with an empty table, the result is zero.
// Reset clears the count register, sequencer and output valid; the table is undefined.
// ----------------------------------------------------------------------------
// piecewise_linear_vector_interp_unit
// Breakpoint table lookup with linear blend of a 3-D displacement.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_vector_interp_unit #(
    parameter int MAX_BREAKPOINTS = 16,
    parameter int FRACTION_BITS   = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    pwl_item_if.sink            item,
    pwl_result_if.source        result,
    pwl_cfg_if.sink             cfg
);

    localparam int AW  = $clog2(MAX_BREAKPOINTS);
    localparam int CW  = $clog2(MAX_BREAKPOINTS + 1);
    localparam int QW  = FRACTION_BITS + 1;
    localparam int DW  = pwl_pkg::DISP_W;
    localparam int HW  = pwl_pkg::HEIGHT_W;
    localparam int EW  = pwl_pkg::ENTRY_W;
    localparam int PW  = (DW + 1) + (QW + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_ADD   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [pwl_pkg::COUNT_W-1:0]     bp_count_reg, bp_count_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   idx_reg, idx_next;
    logic [1:0]                      comp_reg, comp_next;
    logic                            out_valid_reg, out_valid_next;

    logic [HW-1:0]                   dist_reg, dist_next;
    logic [pwl_pkg::TAG_W-1:0]       tag_reg, tag_next;
    logic [HW-1:0]                   prev_h_reg, prev_h_next;
    logic [3*DW-1:0]                 prev_d_reg, prev_d_next;
    logic [3*DW-1:0]                 cur_d_reg, cur_d_next;
    logic [3*DW-1:0]                 res_reg, res_next;
    logic [pwl_pkg::KIND_W-1:0]      kind_reg, kind_next;
    logic signed [PW-1:0]            prod_reg, prod_next;
    logic [pwl_pkg::TAG_W-1:0]       out_tag_reg, out_tag_next;
    logic [3*DW-1:0]                 out_d_reg, out_d_next;
    logic [pwl_pkg::KIND_W-1:0]      out_kind_reg, out_kind_next;

    logic                            in_fire;
    logic                            slot_ok;
    logic [CW-1:0]                   count_eff;
    logic [CW-1:0]                   idx_plus;
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [EW-1:0]                   ram_wdata;
    logic                            ram_re;
    logic [AW-1:0]                   ram_raddr;
    logic [EW-1:0]                   ram_rdata;
    logic [HW-1:0]                   entry_h;
    logic [3*DW-1:0]                 entry_d;

    logic                            div_start;
    logic [HW-1:0]                   div_num;
    logic [HW-1:0]                   div_den;
    logic [QW-1:0]                   div_quot;
    pwl_pkg::div_stat_t              div_stat;

    logic [DW-1:0]                   comp_a;
    logic [DW-1:0]                   comp_b;
    logic signed [DW:0]              comp_diff;
    logic signed [QW:0]              frac_s;
    logic signed [PW-1:0]            prod_shift;

    // Handshakes
    assign item.ready = (state_reg == S_IDLE) && !div_stat.busy;
    assign in_fire    = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // Load path into the breakpoint table
    assign slot_ok   = 32'(item.slot) < MAX_BREAKPOINTS;
    assign ram_we    = in_fire && (item.func == pwl_pkg::FUNC_LOAD) && slot_ok;
    assign ram_waddr = AW'(item.slot);
    assign ram_wdata = {item.load_dz, item.load_dy, item.load_dx, item.height};

    // Clamp the count register to the table depth
    always_comb
    begin
        if (32'(bp_count_reg) > MAX_BREAKPOINTS)
        begin
            count_eff = CW'(MAX_BREAKPOINTS);
        end
        else
        begin
            count_eff = CW'(bp_count_reg);
        end
    end

    // Table read: first entry on fetch, then the next entry every scan cycle
    assign idx_plus  = idx_reg + CW'(1);
    assign ram_re    = (state_reg == S_FETCH) || (state_reg == S_SCAN);
    assign ram_raddr = (state_reg == S_FETCH) ? idx_reg[AW-1:0] : idx_plus[AW-1:0];
    assign entry_h   = ram_rdata[HW-1:0];
    assign entry_d   = ram_rdata[EW-1:HW];

    pwl_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BREAKPOINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pwl_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    // Shared multiplier operands for the current component
    always_comb
    begin
        comp_a     = prev_d_reg[comp_reg * DW +: DW];
        comp_b     = cur_d_reg[comp_reg * DW +: DW];
        comp_diff  = $signed({comp_b[DW-1], comp_b}) - $signed({comp_a[DW-1], comp_a});
        frac_s     = $signed({1'b0, div_quot});
        prod_shift = prod_reg >>> FRACTION_BITS;
    end

    assign div_num = dist_reg - prev_h_reg;
    assign div_den = entry_h - prev_h_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        bp_count_next  = bp_count_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        comp_next      = comp_reg;
        out_valid_next = out_valid_reg;
        dist_next      = dist_reg;
        tag_next       = tag_reg;
        prev_h_next    = prev_h_reg;
        prev_d_next    = prev_d_reg;
        cur_d_next     = cur_d_reg;
        res_next       = res_reg;
        kind_next      = kind_reg;
        prod_next      = prod_reg;
        out_tag_next   = out_tag_reg;
        out_d_next     = out_d_reg;
        out_kind_next  = out_kind_reg;
        div_start      = 1'b0;

        // Take a configuration write
        if (cfg.valid)
        begin
            bp_count_next = cfg.breakpoint_count;
        end

        // Drop the result once transferred
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (item.func == pwl_pkg::FUNC_QUERY))
                begin
                    tag_next   = item.vertex_id;
                    dist_next  = item.distance;
                    count_next = count_eff;
                    idx_next   = '0;
                    res_next   = '0;
                    if (count_eff == '0)
                    begin
                        kind_next  = pwl_pkg::SEG_BEYOND;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                priority if (dist_reg > entry_h)
                begin
                    prev_h_next = entry_h;
                    prev_d_next = entry_d;
                    idx_next    = idx_plus;
                    if (idx_plus == count_reg)
                    begin
                        kind_next  = pwl_pkg::SEG_BEYOND;
                        state_next = S_DONE;
                    end
                end
                else if (idx_reg == '0)
                begin
                    kind_next  = pwl_pkg::SEG_BELOW;
                    res_next   = entry_d;
                    state_next = S_DONE;
                end
                else
                begin
                    cur_d_next = entry_d;
                    kind_next  = pwl_pkg::SEG_INTERP;
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    comp_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = comp_diff * frac_s;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                res_next[comp_reg * DW +: DW] = comp_a + prod_shift[DW-1:0];
                if (comp_reg == 2'd2)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_tag_next   = tag_reg;
                    out_d_next     = res_reg;
                    out_kind_next  = kind_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bp_count_reg  <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            comp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bp_count_reg  <= bp_count_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        dist_reg     <= dist_next;
        tag_reg      <= tag_next;
        prev_h_reg   <= prev_h_next;
        prev_d_reg   <= prev_d_next;
        cur_d_reg    <= cur_d_next;
        res_reg      <= res_next;
        kind_reg     <= kind_next;
        prod_reg     <= prod_next;
        out_tag_reg  <= out_tag_next;
        out_d_reg    <= out_d_next;
        out_kind_reg <= out_kind_next;
    end

    // Drive the result channel
    assign result.valid        = out_valid_reg;
    assign result.tag          = out_tag_reg;
    assign result.out_dx       = out_d_reg[DW-1:0];
    assign result.out_dy       = out_d_reg[2*DW-1:DW];
    assign result.out_dz       = out_d_reg[3*DW-1:2*DW];
    assign result.segment_kind = out_kind_reg;

endmodule

`default_nettype wire

FILE: rtl/pwl_checker.sv
// ----------------------------------------------------------------------------
// pwl_checker
// Port-level checks of the interpolation unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "piecewise_linear_vector_interp_unit_assert.svh"

module pwl_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              item_valid,
    input wire logic                              item_ready,
    input wire logic [pwl_pkg::FUNC_W-1:0]        item_func,
    input wire logic                              result_valid,
    input wire logic                              result_ready,
    input wire logic [pwl_pkg::TAG_W-1:0]         result_tag,
    input wire logic [pwl_pkg::DISP_W-1:0]        result_dx,
    input wire logic [pwl_pkg::DISP_W-1:0]        result_dy,
    input wire logic [pwl_pkg::DISP_W-1:0]        result_dz,
    input wire logic [pwl_pkg::KIND_W-1:0]        result_kind
);

    // After a query transfer, input ready is low in the next cycle
    `PWL_ASSERT_NEXT(a_query_blocks, clk, rst_n,
        item_valid && item_ready && (item_func == pwl_pkg::FUNC_QUERY),
        !item_ready, "input ready right after a query transfer")

    // Out-of-range or empty lookups return zero displacement
    `PWL_ASSERT_SAME(a_beyond_zero, clk, rst_n,
        result_valid && (result_kind == pwl_pkg::SEG_BEYOND),
        (result_dx == '0) && (result_dy == '0) && (result_dz == '0),
        "nonzero displacement for beyond-table result")

    // Segment kind is one of the three legal codes
    `PWL_ASSERT_SAME(a_kind_legal, clk, rst_n,
        result_valid,
        (result_kind == pwl_pkg::SEG_BELOW) || (result_kind == pwl_pkg::SEG_INTERP) ||
            (result_kind == pwl_pkg::SEG_BEYOND),
        "illegal segment kind")

    // A stalled result holds its tag, x displacement and segment kind
    `PWL_ASSERT_NEXT(a_result_hold, clk, rst_n,
        result_valid && !result_ready,
        result_valid && $stable(result_tag) && $stable(result_dx) && $stable(result_kind),
        "result changed while stalled")

endmodule

bind piecewise_linear_vector_interp_unit pwl_checker u_pwl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_func    (item.func),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_tag   (result.tag),
    .result_dx    (result.out_dx),
    .result_dy    (result.out_dy),
    .result_dz    (result.out_dz),
    .result_kind  (result.segment_kind)
);

`default_nettype wire
